### design/rms_pkg.sv
package rms_pkg;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int DRAW_W   = 31;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

### design/randomized_multiset_store.sv
// Multiset store of up to CAPACITY signed 32-bit values with duplicates allowed.
// Each word on the slave side is one command: insert, remove or sample; each
// produces exactly one result word. The block takes one command at a time and
// is not ready while it works. An insert or a remove walks the stored entries
// one by one through the single memory read port and one comparator, with a
// read state and a compare state for each; a sample waits on the bit-serial
// modulo unit that works one draw bit a cycle. Commands that find the store
// full or empty go straight to the result state. A finished result sits in
// an output register until the master side takes it.
module randomized_multiset_store #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // item_value[31:0], random_draw[62:32], zero
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // answer_flag[0], sampled_value[32:1],
                                        // occupancy[39:33]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_WRITE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DIV,
        S_SMP_RD,
        S_SMP_CAP,
        S_DONE
    } state_t;

    state_t                              state_reg;
    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       idx_reg;
    logic [rms_pkg::CMD_W-1:0]           cmd_reg;
    logic [rms_pkg::VALUE_W-1:0]         value_reg;
    logic                                flag_reg;
    logic [rms_pkg::VALUE_W-1:0]         sampled_reg;
    logic [rms_pkg::STATUS_W-1:0]        status_reg;

    logic                                out_valid_reg;
    logic                                out_flag_reg;
    logic [rms_pkg::VALUE_W-1:0]         out_sampled_reg;
    logic [rms_pkg::STATUS_W-1:0]        out_status_reg;
    logic [rms_pkg::OCC_W-1:0]           out_occ_reg;

    logic [rms_pkg::VALUE_W-1:0]         mem [CAPACITY];
    logic [rms_pkg::VALUE_W-1:0]         rd_data_reg;
    logic [AW-1:0]                       mem_rd_addr;
    logic [AW-1:0]                       mem_wr_addr;
    logic [rms_pkg::VALUE_W-1:0]         mem_wr_data;
    logic                                mem_we;

    logic                                div_start;
    logic                                div_done;
    logic [CW-1:0]                       div_rem;

    logic                                in_fire;
    logic                                out_free;
    logic                                last_idx;
    logic [CW-1:0]                       count_dec;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign last_idx  = ((idx_reg + CW'(1)) == count_reg);
    assign count_dec = count_reg - CW'(1);
    assign div_start = (state_reg == S_IDLE) && in_fire
                       && (s_axis_tuser == rms_pkg::CMD_SAMPLE) && (count_reg != '0);

    rms_mod #(
        .CW (CW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (s_axis_tdata[62:32]),
        .divisor   (count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        case (state_reg)
            S_SEARCH:  mem_rd_addr = AW'(idx_reg);
            S_MOVE_RD: mem_rd_addr = AW'(count_dec);
            S_SMP_RD:  mem_rd_addr = AW'(div_rem);
            default:   mem_rd_addr = '0;
        endcase
    end

    always_comb
    begin
        mem_we      = 1'b0;
        mem_wr_addr = AW'(count_reg);
        mem_wr_data = value_reg;
        case (state_reg)
            S_WRITE:
            begin
                mem_we = 1'b1;
            end
            S_MOVE_WR:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = AW'(idx_reg);
                mem_wr_data = rd_data_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        rd_data_reg <= mem[mem_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            idx_reg         <= '0;
            cmd_reg         <= rms_pkg::CMD_INSERT;
            value_reg       <= '0;
            flag_reg        <= 1'b0;
            sampled_reg     <= '0;
            status_reg      <= rms_pkg::ST_OK;
            out_valid_reg   <= 1'b0;
            out_flag_reg    <= 1'b0;
            out_sampled_reg <= '0;
            out_status_reg  <= rms_pkg::ST_OK;
            out_occ_reg     <= '0;
        end
        else
        begin
            // A result taken while the next one is ready is replaced in S_DONE instead.
            if (out_valid_reg && m_axis_tready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        cmd_reg     <= s_axis_tuser;
                        value_reg   <= s_axis_tdata[31:0];
                        idx_reg     <= '0;
                        flag_reg    <= 1'b0;
                        sampled_reg <= '0;
                        status_reg  <= rms_pkg::ST_OK;
                        state_reg   <= S_DONE;
                        case (s_axis_tuser)
                            rms_pkg::CMD_INSERT:
                            begin
                                if (count_reg == CW'(CAPACITY))
                                begin
                                    status_reg <= rms_pkg::ST_FULL;
                                end
                                else if (count_reg == '0)
                                begin
                                    flag_reg  <= 1'b1;
                                    state_reg <= S_WRITE;
                                end
                                else
                                begin
                                    state_reg <= S_SEARCH;
                                end
                            end
                            rms_pkg::CMD_REMOVE:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= rms_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    state_reg <= S_SEARCH;
                                end
                            end
                            rms_pkg::CMD_SAMPLE:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= rms_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    state_reg <= S_DIV;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SEARCH:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (rd_data_reg == value_reg)
                    begin
                        if (cmd_reg == rms_pkg::CMD_INSERT)
                        begin
                            flag_reg  <= 1'b0;
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            state_reg <= S_MOVE_RD;
                        end
                    end
                    else if (last_idx)
                    begin
                        // Value absent: an insert reports it as new, a remove does nothing.
                        if (cmd_reg == rms_pkg::CMD_INSERT)
                        begin
                            flag_reg  <= 1'b1;
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SEARCH;
                    end
                end
                S_WRITE:
                begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_DONE;
                end
                S_MOVE_RD:
                begin
                    state_reg <= S_MOVE_WR;
                end
                S_MOVE_WR:
                begin
                    count_reg <= count_dec;
                    flag_reg  <= 1'b1;
                    state_reg <= S_DONE;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SMP_RD;
                    end
                end
                S_SMP_RD:
                begin
                    state_reg <= S_SMP_CAP;
                end
                S_SMP_CAP:
                begin
                    sampled_reg <= rd_data_reg;
                    state_reg   <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_flag_reg    <= flag_reg;
                        out_sampled_reg <= sampled_reg;
                        out_status_reg  <= status_reg;
                        out_occ_reg     <= rms_pkg::OCC_W'(count_reg);
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_occ_reg, out_sampled_reg, out_flag_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

### design/rms_mod.sv
module rms_mod #(
    parameter int CW = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rms_pkg::DRAW_W-1:0]  dividend,
    input  logic [CW-1:0]               divisor,
    output logic                        done,
    output logic [CW-1:0]               remainder
);

    localparam int NW = $clog2(rms_pkg::DRAW_W + 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [NW-1:0]              cnt_reg;
    logic [rms_pkg::DRAW_W-1:0] dvd_reg;
    logic [CW-1:0]              rem_reg;

    logic [CW:0]                trial;
    logic [CW:0]                diff;
    logic [CW-1:0]              rem_step;

    // Restoring division, one dividend bit per cycle; only the remainder is kept.
    assign trial    = {rem_reg, dvd_reg[rms_pkg::DRAW_W-1]};
    assign diff     = trial - {1'b0, divisor};
    assign rem_step = (trial >= {1'b0, divisor}) ? diff[CW-1:0] : trial[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= NW'(rms_pkg::DRAW_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - NW'(1);
            if (cnt_reg == NW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[rms_pkg::DRAW_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
